### design/dsw_pkg.sv
package dsw_pkg;

  localparam int unsigned DELTA_WIDTH = 16;

  localparam logic [13:0] YEAR_MIN = 14'd1;
  localparam logic [13:0] YEAR_MAX = 14'd9999;
  localparam logic [13:0] YEAR_RST = 14'd2000;
  localparam logic [3:0]  MONTH_RST = 4'd1;
  localparam logic [4:0]  DAY_RST = 5'd1;
  localparam logic [6:0]  YY_RST = 7'd0;
  localparam logic [1:0]  CENT_RST = 2'd0;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SHIFT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_DIV,
    ST_LD_YY,
    ST_LD_CLAMP,
    ST_WALK,
    ST_WD_SUM,
    ST_WD_OUT
  } dsw_state_e;

  typedef struct packed {
    logic capture;
    logic ld_div;
    logic ld_yy;
    logic ld_clamp;
    logic walk;
    logic wd_sum;
    logic out_load;
  } dsw_cmd_t;

  typedef struct packed {
    logic walk_done;
  } dsw_status_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] month_key(input logic [3:0] m);
    logic [2:0] key;
    case (m)
      4'd1:    key = 3'd0;
      4'd2:    key = 3'd3;
      4'd3:    key = 3'd3;
      4'd4:    key = 3'd6;
      4'd5:    key = 3'd1;
      4'd6:    key = 3'd4;
      4'd7:    key = 3'd6;
      4'd8:    key = 3'd2;
      4'd9:    key = 3'd5;
      4'd10:   key = 3'd0;
      4'd11:   key = 3'd3;
      4'd12:   key = 3'd5;
      default: key = 3'd0;
    endcase
    return key;
  endfunction

endpackage

### design/dsw_ctrl.sv
module dsw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cmd_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  dsw_pkg::dsw_status_t sts_i,
  output dsw_pkg::dsw_cmd_t    ctl_o
);
  import dsw_pkg::*;

  dsw_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d = (cmd_i == CMD_SHIFT) ? ST_WALK : ST_LD_DIV;
        end
      end
      ST_LD_DIV: begin
        ctl_o.ld_div = 1'b1;
        state_d = ST_LD_YY;
      end
      ST_LD_YY: begin
        ctl_o.ld_yy = 1'b1;
        state_d = ST_LD_CLAMP;
      end
      ST_LD_CLAMP: begin
        ctl_o.ld_clamp = 1'b1;
        state_d = ST_WD_SUM;
      end
      ST_WALK: begin
        ctl_o.walk = 1'b1;
        if (sts_i.walk_done) begin
          state_d = ST_WD_SUM;
        end
      end
      ST_WD_SUM: begin
        ctl_o.wd_sum = 1'b1;
        state_d = ST_WD_OUT;
      end
      ST_WD_OUT: begin
        if (out_free) begin
          ctl_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

endmodule

### design/dsw_datapath.sv
module dsw_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dsw_pkg::dsw_cmd_t                      ctl_i,
  output dsw_pkg::dsw_status_t                   sts_o,
  input  logic [13:0]                            load_year_i,
  input  logic [3:0]                             load_month_i,
  input  logic [4:0]                             load_day_i,
  input  logic signed [dsw_pkg::DELTA_WIDTH-1:0] day_delta_i,
  output logic [13:0]                            cur_year_o,
  output logic [3:0]                             cur_month_o,
  output logic [4:0]                             cur_day_o,
  output logic [2:0]                             week_day_o,
  output logic                                   range_error_o
);
  import dsw_pkg::*;

  localparam int unsigned DW = DELTA_WIDTH;

  logic [13:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [6:0]  yy_q, yy_d;
  logic [1:0]  cent_q, cent_d;

  logic [13:0] bk_year_q;
  logic [3:0]  bk_month_q;
  logic [4:0]  bk_day_q;
  logic [6:0]  bk_yy_q;
  logic [1:0]  bk_cent_q;

  logic [13:0] ld_year_q;
  logic [3:0]  ld_month_q;
  logic [4:0]  ld_day_q;
  logic [6:0]  q100_q;
  logic        err_q;
  logic [7:0]  wsum_q;
  logic signed [DW-1:0] rem_q;

  logic [13:0] year_c;
  logic [3:0]  month_c;
  logic [26:0] div_prod;
  logic [13:0] yy_full;
  logic        leap;
  logic [4:0]  mlen;
  logic [4:0]  mlen_prev;
  logic signed [DW:0] day_sum;
  logic        fits;
  logic        at_end;
  logic        walk_err;
  logic [5:0]  fwd_step;
  logic signed [DW-1:0] rem_d;
  logic [7:0]  wsum_d;
  logic [15:0] mod_prod;
  logic [4:0]  q7;
  logic [7:0]  wday_full;

  // The Gregorian rule: divisible by 4, and a century only when divisible by 400.
  assign leap = (year_q[1:0] == 2'd0) && ((yy_q != 7'd0) || (cent_q == 2'd0));
  assign mlen = month_len(month_q, leap);
  assign mlen_prev = (month_q == MONTH_JAN) ? 5'd31 : month_len(month_q - 4'd1, leap);

  always_comb begin
    if (ld_year_q < YEAR_MIN) begin
      year_c = YEAR_MIN;
    end else if (ld_year_q > YEAR_MAX) begin
      year_c = YEAR_MAX;
    end else begin
      year_c = ld_year_q;
    end
    if (ld_month_q == 4'd0) begin
      month_c = MONTH_JAN;
    end else if (ld_month_q > MONTH_DEC) begin
      month_c = MONTH_DEC;
    end else begin
      month_c = ld_month_q;
    end
  end

  // The year over 100 is taken as a product with the scaled reciprocal.
  assign div_prod = 27'(year_c) * 27'd5243;
  assign yy_full  = year_q - 14'(q100_q) * 14'd100;

  assign day_sum  = signed'({rem_q[DW-1], rem_q}) + signed'({{(DW-4){1'b0}}, day_q});
  assign fwd_step = 6'(mlen) - 6'(day_q) + 6'd1;

  always_comb begin
    if (!rem_q[DW-1]) begin
      fits   = (day_sum <= signed'({{(DW-4){1'b0}}, mlen}));
      at_end = (month_q == MONTH_DEC) && (year_q == YEAR_MAX);
      rem_d  = rem_q - signed'({{(DW-6){1'b0}}, fwd_step});
    end else begin
      fits   = (day_sum > signed'({(DW+1){1'b0}}));
      at_end = (month_q == MONTH_JAN) && (year_q == YEAR_MIN);
      rem_d  = rem_q + signed'({{(DW-5){1'b0}}, day_q});
    end
  end

  assign walk_err = !fits && at_end;
  assign sts_o.walk_done = fits || at_end;

  always_comb begin
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    yy_d    = yy_q;
    cent_d  = cent_q;
    if (ctl_i.ld_div) begin
      year_d  = year_c;
      month_d = month_c;
      day_d   = (ld_day_q == 5'd0) ? DAY_RST : ld_day_q;
    end else if (ctl_i.ld_yy) begin
      yy_d   = yy_full[6:0];
      cent_d = q100_q[1:0];
    end else if (ctl_i.ld_clamp) begin
      if (day_q > mlen) begin
        day_d = mlen;
      end
    end else if (ctl_i.walk) begin
      if (fits) begin
        day_d = day_sum[4:0];
      end else if (walk_err) begin
        year_d  = bk_year_q;
        month_d = bk_month_q;
        day_d   = bk_day_q;
        yy_d    = bk_yy_q;
        cent_d  = bk_cent_q;
      end else if (!rem_q[DW-1]) begin
        day_d = DAY_RST;
        if (month_q == MONTH_DEC) begin
          month_d = MONTH_JAN;
          year_d  = year_q + 14'd1;
          if (yy_q == 7'd99) begin
            yy_d   = 7'd0;
            cent_d = cent_q + 2'd1;
          end else begin
            yy_d = yy_q + 7'd1;
          end
        end else begin
          month_d = month_q + 4'd1;
        end
      end else begin
        day_d = mlen_prev;
        if (month_q == MONTH_JAN) begin
          month_d = MONTH_DEC;
          year_d  = year_q - 14'd1;
          if (yy_q == 7'd0) begin
            yy_d   = 7'd99;
            cent_d = cent_q - 2'd1;
          end else begin
            yy_d = yy_q - 7'd1;
          end
        end else begin
          month_d = month_q - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q  <= YEAR_RST;
      month_q <= MONTH_RST;
      day_q   <= DAY_RST;
      yy_q    <= YY_RST;
      cent_q  <= CENT_RST;
    end else begin
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      yy_q    <= yy_d;
      cent_q  <= cent_d;
    end
  end

  // Sum of the key-value method; it stays below 167.
  assign wsum_d = 8'(yy_q) + 8'(yy_q[6:2]) + 8'(month_key(month_q))
                + 8'(3'd6 - {cent_q, 1'b0}) + 8'(day_q)
                - 8'(leap && (month_q <= MONTH_FEB));

  assign mod_prod  = 16'(wsum_q) * 16'd293;
  assign q7        = mod_prod[15:11];
  assign wday_full = wsum_q - 8'(q7) * 8'd7;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      bk_year_q  <= year_q;
      bk_month_q <= month_q;
      bk_day_q   <= day_q;
      bk_yy_q    <= yy_q;
      bk_cent_q  <= cent_q;
      ld_year_q  <= load_year_i;
      ld_month_q <= load_month_i;
      ld_day_q   <= load_day_i;
      rem_q      <= day_delta_i;
      err_q      <= 1'b0;
    end else if (ctl_i.walk) begin
      rem_q <= rem_d;
      if (walk_err) begin
        err_q <= 1'b1;
      end
    end
    if (ctl_i.ld_div) begin
      q100_q <= div_prod[25:19];
    end
    if (ctl_i.wd_sum) begin
      wsum_q <= wsum_d;
    end
    if (ctl_i.out_load) begin
      cur_year_o    <= year_q;
      cur_month_o   <= month_q;
      cur_day_o     <= day_q;
      week_day_o    <= wday_full[2:0];
      range_error_o <= err_q;
    end
  end

endmodule

### design/date_shift_with_weekday_unit.sv
// Holds one Gregorian date, reset to 2000-01-01, and answers every input word with
// one output word carrying the stored date, its weekday (0 is Sunday) and a range
// flag. A load word (cmd 0) replaces the date, with out-of-range fields clamped.
// A shift word (cmd 1) walks the date one calendar month per cycle. A shift that
// would leave the years 1 to 9999 keeps the old date and sets range_error. One
// word is worked on at a time; the result sits in an output register, so the
// next input word is taken while an earlier result still waits.
module date_shift_with_weekday_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   cmd_i,
  input  logic [13:0]                            load_year_i,
  input  logic [3:0]                             load_month_i,
  input  logic [4:0]                             load_day_i,
  input  logic signed [dsw_pkg::DELTA_WIDTH-1:0] day_delta_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [13:0]                            cur_year_o,
  output logic [3:0]                             cur_month_o,
  output logic [4:0]                             cur_day_o,
  output logic [2:0]                             week_day_o,
  output logic                                   range_error_o
);
  import dsw_pkg::*;

  dsw_cmd_t    ctl;
  dsw_status_t sts;

  dsw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  dsw_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .load_year_i   (load_year_i),
    .load_month_i  (load_month_i),
    .load_day_i    (load_day_i),
    .day_delta_i   (day_delta_i),
    .cur_year_o    (cur_year_o),
    .cur_month_o   (cur_month_o),
    .cur_day_o     (cur_day_o),
    .week_day_o    (week_day_o),
    .range_error_o (range_error_o)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a word is still in work");

  a_result_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cur_month_o >= 4'd1) && (cur_month_o <= 4'd12) &&
                    (cur_day_o != 5'd0) && (week_day_o <= 3'd6) &&
                    (cur_year_o >= 14'd1) && (cur_year_o <= 14'd9999))
    else $error("result is not a valid date");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |=> out_valid_o)
    else $error("loaded result not presented");
`endif

endmodule
